// File: src/als_pkg.sv
// Shared types and constants for the addressable LED line serializer.
// Holds the input, result and register word structs and the register indexes.
// No dependencies.
package als_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 2'd3;

	// Register reset values
	localparam logic [15:0] ONE_HIGH_RST  = 16'd38;
	localparam logic [15:0] ZERO_HIGH_RST = 16'd19;
	localparam logic [15:0] PERIOD_RST    = 16'd60;
	localparam logic [19:0] LATCH_RST     = 20'd2880;

	// Command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic line_level;
		logic ready_res;
		logic busy_res;
		logic refused;
	} out_word_t;

	typedef struct packed {
		logic [15:0] one_high_ticks;
		logic [15:0] zero_high_ticks;
		logic [15:0] bit_period_ticks;
		logic [19:0] latch_ticks;
	} cfg_regs_t;

endpackage

// File: src/als_cfg.sv
// Configuration register file of the LED line serializer.
// Depends on als_pkg for the register struct, indexes and reset values.
module als_cfg
	import als_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	// Always take a write
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and store the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.one_high_ticks   <= ONE_HIGH_RST;
			regs_q.zero_high_ticks  <= ZERO_HIGH_RST;
			regs_q.bit_period_ticks <= PERIOD_RST;
			regs_q.latch_ticks      <= LATCH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ONE_HIGH:  regs_q.one_high_ticks   <= cfg_data[15:0];
				REG_ZERO_HIGH: regs_q.zero_high_ticks  <= cfg_data[15:0];
				REG_PERIOD:    regs_q.bit_period_ticks <= cfg_data[15:0];
				REG_LATCH:     regs_q.latch_ticks      <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/als_core.sv
// Bit sequencer of the LED line serializer: holding register, shifter and
// phase counter, advanced by one tick per accepted word.
// Depends on als_pkg for the word structs and command codes.
module als_core
	import als_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      acc,
	input  in_word_t  in_word,
	input  cfg_regs_t cfg,
	output out_word_t res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bits_left_q, bits_left_d;
	logic [19:0] count_q, count_d;
	logic        cur_last_q, cur_last_d;
	logic [7:0]  held_byte_q, held_byte_d;
	logic        held_valid_q, held_valid_d;
	logic        held_last_q, held_last_d;
	logic        load;
	logic [15:0] hi;
	logic [19:0] count_inc;

	// Work out one tick of the waveform
	always_comb begin
		load         = (in_word.command == CMD_LOAD);
		phase_d      = phase_q;
		shift_d      = shift_q;
		bits_left_d  = bits_left_q;
		count_d      = count_q;
		cur_last_d   = cur_last_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		held_last_d  = held_last_q;
		res.refused  = load & held_valid_q;

		// Take a load into the holding register unless it is full
		if (load && !held_valid_q) begin
			held_byte_d  = in_word.data_byte;
			held_last_d  = in_word.last_byte;
			held_valid_d = 1'b1;
		end

		// Move the held byte into the shifter when idle
		if (phase_q == PH_IDLE && held_valid_d) begin
			shift_d      = held_byte_d;
			cur_last_d   = held_last_d;
			held_valid_d = 1'b0;
			bits_left_d  = 4'd8;
			count_d      = '0;
			hi           = held_byte_d[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
			phase_d      = (hi == '0) ? PH_LOW : PH_HIGH;
		end

		res.line_level = (phase_d == PH_HIGH);
		res.busy_res   = (phase_d != PH_IDLE);

		// Advance the phase counter
		hi        = shift_d[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
		count_inc = count_d + 20'd1;
		case (phase_d)
			PH_HIGH, PH_LOW: begin
				count_d = count_inc;
				if (count_inc >= {4'd0, cfg.bit_period_ticks}) begin
					shift_d     = {shift_d[6:0], 1'b0};
					bits_left_d = bits_left_d - 4'd1;
					count_d     = '0;
					if (bits_left_d == 4'd0) begin
						phase_d = cur_last_d ? PH_LATCH : PH_IDLE;
					end else begin
						hi      = shift_d[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
						phase_d = (hi == '0) ? PH_LOW : PH_HIGH;
					end
				end else if (phase_d == PH_HIGH && count_inc >= {4'd0, hi}) begin
					phase_d = PH_LOW;
				end
			end
			PH_LATCH: begin
				count_d = count_inc;
				if (count_inc >= cfg.latch_ticks) begin
					count_d = '0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
			end
		endcase

		res.ready_res = ~held_valid_d;
	end

	// Hold the sequencer state between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			shift_q      <= '0;
			bits_left_q  <= '0;
			count_q      <= '0;
			cur_last_q   <= 1'b0;
			held_valid_q <= 1'b0;
			held_last_q  <= 1'b0;
		end else if (acc) begin
			phase_q      <= phase_d;
			shift_q      <= shift_d;
			bits_left_q  <= bits_left_d;
			count_q      <= count_d;
			cur_last_q   <= cur_last_d;
			held_valid_q <= held_valid_d;
			held_last_q  <= held_last_d;
		end
	end

	// The held byte needs no reset: it is read only while marked valid
	always_ff @(posedge clk) begin
		if (acc) begin
			held_byte_q <= held_byte_d;
		end
	end

`ifndef SYNTHESIS
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.refused |-> held_valid_q)
		else $error("load refused with empty holding register");

	a_idle_no_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bits_left_q == 4'd0)
		else $error("idle with bits still to send");

	a_hold_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && load && !held_valid_q && phase_q != PH_IDLE && phase_q != PH_LATCH
		&& bits_left_q > 4'd1 |=> held_valid_q)
		else $error("byte loaded mid-frame was not held");

	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.line_level |=> phase_q != PH_IDLE || bits_left_q == 4'd0)
		else $error("line driven high outside a bit");
`endif

endmodule

// File: src/als_skid.sv
// Two-entry result buffer of the LED line serializer: an output register and
// a skid register that parts the result channel from the input channel.
// Depends on als_pkg for the result word struct.
module als_skid
	import als_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t push_word,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	out_word_t main_q, skid_q;
	logic      main_valid_q, skid_valid_q;
	logic      pop;

	assign pop       = main_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Track which entries hold a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Move the payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_word;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_word;
			end else begin
				main_q <= push_word;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry filled ahead of output entry");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q && $stable(skid_q))
		else $error("skid word lost while stalled");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q && skid_valid_q && out_stall |=> main_valid_q && skid_valid_q)
		else $error("full buffer changed while stalled");
`endif

endmodule

// File: src/addressable_led_serializer.sv
// Top level of the addressable LED line serializer.
// Depends on als_pkg, als_cfg, als_core and als_skid.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): each word is one clock tick
//   of the LED waveform; command selects a plain tick or a byte load, with
//   data_byte and last_byte carried alongside. A word is taken at an edge
//   with in_valid high and in_stall low.
//   Result channel (out_valid, out_stall, out_data): exactly one result word
//   per input word, in order, with the line level, holding register state,
//   busy flag and refusal flag for that tick.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): write the bit
//   timing and latch length while no frame is running; cfg_ready is always 1.
// Throughput: one input word per cycle while in_stall is low; the sequencer
//   steps in a single pass from its state registers, so a tick follows a tick in the next cycle.
// Result path: a result is registered in the result buffer and shows on out_valid.
// Stall: a two-entry result buffer absorbs one stalled result; with both
//   entries full, in_stall rises until the receiver takes a word.
// Reset: arst_n clears the sequencer to idle with an empty holding register,
//   empties the result buffer and restores the default timing registers.
module addressable_led_serializer
	import als_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_regs_t cfg;
	out_word_t res;
	logic      acc;
	logic      full;

	// Accept a word whenever the skid entry is free
	assign in_stall = full;
	assign acc      = in_valid & ~full;

	als_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	als_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_word (in_data),
		.cfg     (cfg),
		.res     (res)
	);

	als_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_word (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
